// File: design/mqd_pkg.sv
// shared types and constants for the multilevel queue dispatcher
`timescale 1ns / 1ps
`default_nettype none
package mqd_pkg;

    localparam int OP_W          = 2;
    localparam int VAL_W         = 16;
    localparam int TIME_W        = 21;
    localparam int KIND_W        = 3;
    localparam int PID_W         = 5;
    localparam int DEF_MAX_PROCS = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_QUANTUM   = 1'b0;
    localparam logic [VAL_W-1:0]     QUANTUM_RESET = 16'd4;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_CLEAR    = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOADED     = 3'd0,
        KIND_REFUSED    = 3'd1,
        KIND_SYS_RUN    = 3'd2,
        KIND_USER_SLICE = 3'd3,
        KIND_IDLE       = 3'd4,
        KIND_DONE       = 3'd5,
        KIND_CLEARED    = 3'd6
    } t_kind;

    typedef struct packed {
        logic [VAL_W-1:0] arrival;
        logic [VAL_W-1:0] burst;
        logic [VAL_W-1:0] remaining;
        logic             cls;
    } t_entry;

    typedef struct packed {
        t_kind             kind;
        logic [PID_W-1:0]  proc_id;
        logic [TIME_W-1:0] start_time;
        logic [VAL_W-1:0]  run_length;
        logic              completed;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } t_result;

    typedef struct packed {
        logic cap_in;
        logic do_load;
        logic do_clear;
        logic scan_start;
        logic scan_from_pos;
        logic scan_sys;
        logic scan_step;
        logic sweep_end;
        logic sweep_begin;
        logic set_idle;
        logic set_done;
        logic run_start;
        logic run_tat;
        logic run_wait;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_active;
        logic            all_done;
        logic            ran_any;
        logic            found;
        logic            scan_done;
        logic            out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: design/mqd_in_if.sv
// request channel interface
`timescale 1ns / 1ps
`default_nettype none
interface mqd_in_if;
    import mqd_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [VAL_W-1:0]  arrival;
    logic [VAL_W-1:0]  burst;
    logic              proc_class;

    modport source (output valid, op, arrival, burst, proc_class, input ready);
    modport sink   (input valid, op, arrival, burst, proc_class, output ready);
endinterface
`default_nettype wire

// File: design/mqd_out_if.sv
// event channel interface
`timescale 1ns / 1ps
`default_nettype none
interface mqd_out_if;
    import mqd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  proc_id;
    logic [TIME_W-1:0] start_time;
    logic [VAL_W-1:0]  run_length;
    logic              completed;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;

    modport source (output valid, kind, proc_id, start_time, run_length, completed,
                    completion_time, turnaround, waiting, input ready);
    modport sink   (input valid, kind, proc_id, start_time, run_length, completed,
                    completion_time, turnaround, waiting, output ready);
endinterface
`default_nettype wire

// File: design/multilevel_queue_dispatcher_top.sv
// multilevel queue dispatcher top level
//
// channel   dir  transfer   payload
// i_in      in   valid/rdy  op, arrival, burst, proc_class
// o_out     out  valid/rdy  kind, proc_id, start_time, run_length, completed,
//                           completion_time, turnaround, waiting
// apb       in   psel/pen   quantum at word 0
//
// one request at a time; load and clear go through decode and emit to reach the output register
// dispatch walks the process table through a registered-read memory with separate read
// and write addresses, one entry per cycle; a walk may resume a sweep from its saved position,
// and there are at most three walks per request
// synchronous reset, no table clearing pass; table entries hold garbage until loaded
// the output register holds an event while the next request is taken and decoded
`timescale 1ns / 1ps
`default_nettype none
module multilevel_queue_dispatcher_top #(
    parameter int MAX_PROCS = mqd_pkg::DEF_MAX_PROCS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    mqd_in_if.sink                                i_in,
    mqd_out_if.source                             o_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mqd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mqd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mqd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import mqd_pkg::*;

    logic [VAL_W-1:0]     r_quantum;
    logic [REG_IDX_W-1:0] reg_idx;
    t_cmd                 cmd;
    t_sts                 sts;
    t_result              result;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_QUANTUM) ? APB_DATA_W'(r_quantum) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_QUANTUM)) begin
            r_quantum <= pwdata[VAL_W-1:0];
        end
    end

    mqd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mqd_dpath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_quantum    (r_quantum),
        .i_op         (i_in.op),
        .i_arrival    (i_in.arrival),
        .i_burst      (i_in.burst),
        .i_proc_class (i_in.proc_class),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_result     (result)
    );

    assign o_out.kind            = result.kind;
    assign o_out.proc_id         = result.proc_id;
    assign o_out.start_time      = result.start_time;
    assign o_out.run_length      = result.run_length;
    assign o_out.completed       = result.completed;
    assign o_out.completion_time = result.completion_time;
    assign o_out.turnaround      = result.turnaround;
    assign o_out.waiting         = result.waiting;
endmodule
`default_nettype wire

// File: design/mqd_ctrl.sv
// dispatcher controller state machine
`timescale 1ns / 1ps
`default_nettype none
module mqd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  mqd_pkg::t_sts      i_sts,
    output mqd_pkg::t_cmd      o_cmd
);
    import mqd_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DECODE   = 12'b0000_0000_0010,
        S_CHECK    = 12'b0000_0000_0100,
        S_SW_SCAN  = 12'b0000_0000_1000,
        S_SW_END   = 12'b0000_0001_0000,
        S_SYS_SCAN = 12'b0000_0010_0000,
        S_RUN1     = 12'b0000_0100_0000,
        S_RUN2     = 12'b0000_1000_0000,
        S_RUN3     = 12'b0001_0000_0000,
        S_EMIT     = 12'b0010_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_LOAD: begin
                        o_cmd.do_load = 1'b1;
                        n_state       = S_EMIT;
                    end
                    OP_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state        = S_EMIT;
                    end
                    OP_DISPATCH: begin
                        if (i_sts.sweep_active) begin
                            o_cmd.scan_start    = 1'b1;
                            o_cmd.scan_from_pos = 1'b1;
                            n_state             = S_SW_SCAN;
                        end else begin
                            n_state = S_CHECK;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CHECK: begin
                if (i_sts.all_done) begin
                    o_cmd.set_done = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_sys   = 1'b1;
                    n_state          = S_SYS_SCAN;
                end
            end
            S_SW_SCAN: begin
                if (i_sts.found) begin
                    n_state = S_RUN1;
                end else if (i_sts.scan_done) begin
                    n_state = S_SW_END;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_SW_END: begin
                o_cmd.sweep_end = 1'b1;
                if (i_sts.ran_any) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.set_idle = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_SYS_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.found) begin
                        n_state = S_RUN1;
                    end else begin
                        o_cmd.sweep_begin = 1'b1;
                        o_cmd.scan_start  = 1'b1;
                        n_state           = S_SW_SCAN;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_RUN1: begin
                o_cmd.run_start = 1'b1;
                n_state         = S_RUN2;
            end
            S_RUN2: begin
                o_cmd.run_tat = 1'b1;
                n_state       = S_RUN3;
            end
            S_RUN3: begin
                o_cmd.run_wait = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: design/mqd_dpath.sv
// dispatcher datapath: process table, clock, scan pipeline and result register
`timescale 1ns / 1ps
`default_nettype none
module mqd_dpath #(
    parameter int MAX_PROCS = mqd_pkg::DEF_MAX_PROCS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  mqd_pkg::t_cmd                    i_cmd,
    output mqd_pkg::t_sts                    o_sts,
    input  wire logic [mqd_pkg::VAL_W-1:0]   i_quantum,
    input  wire logic [mqd_pkg::OP_W-1:0]    i_op,
    input  wire logic [mqd_pkg::VAL_W-1:0]   i_arrival,
    input  wire logic [mqd_pkg::VAL_W-1:0]   i_burst,
    input  wire logic                        i_proc_class,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output mqd_pkg::t_result                 o_result
);
    import mqd_pkg::*;

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    // captured request
    logic [OP_W-1:0]   r_op;
    logic [VAL_W-1:0]  r_arr_in;
    logic [VAL_W-1:0]  r_burst_in;
    logic              r_cls_in;

    // scheduler state
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_finished;
    logic [TIME_W-1:0] r_clock;
    logic              r_sweep_active;
    logic [CW-1:0]     r_sweep_pos;
    logic              r_ran_any;

    // scan pipeline
    logic [CW-1:0]     r_scan_idx;
    logic              r_scan_sys;
    logic              r_pipe_vld;
    logic [IW-1:0]     r_pipe_idx;
    logic              r_found;
    logic [IW-1:0]     r_best_idx;
    logic [VAL_W-1:0]  r_best_arr;
    logic [VAL_W-1:0]  r_best_burst;
    logic [VAL_W-1:0]  r_best_rem;

    t_result           r_res;
    t_result           n_res;
    t_result           r_out;
    logic              r_out_valid;

    t_entry            mem [MAX_PROCS];
    t_entry            r_rd;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    t_entry            mem_wdata;

    logic              load_ok;
    logic              issue;
    logic              cand_ready;
    logic              take;
    logic [VAL_W-1:0]  q_eff;
    logic [VAL_W-1:0]  run_len;
    logic [VAL_W-1:0]  rem_new;
    logic [TIME_W-1:0] clock_next;

    assign load_ok = (r_burst_in != '0) && (r_count < CW'(MAX_PROCS));
    assign issue   = (r_scan_idx < r_count);

    assign cand_ready = r_pipe_vld && (r_rd.remaining != '0) &&
                        (r_rd.cls == ~r_scan_sys) &&
                        ({{(TIME_W-VAL_W){1'b0}}, r_rd.arrival} <= r_clock);
    assign take = cand_ready &&
                  (!r_found || (r_scan_sys && (r_rd.arrival < r_best_arr)));

    assign q_eff      = (i_quantum == '0) ? VAL_W'(1) : i_quantum;
    assign run_len    = (r_scan_sys || (r_best_rem <= q_eff)) ? r_best_rem : q_eff;
    assign rem_new    = r_best_rem - run_len;
    assign clock_next = r_clock + TIME_W'(run_len);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_best_idx;
        mem_wdata = '{arrival: r_best_arr, burst: r_best_burst,
                      remaining: rem_new, cls: ~r_scan_sys};
        if (i_cmd.do_load && load_ok) begin
            mem_we    = 1'b1;
            mem_waddr = r_count[IW-1:0];
            mem_wdata = '{arrival: r_arr_in, burst: r_burst_in,
                          remaining: r_burst_in, cls: r_cls_in};
        end else if (i_cmd.run_start) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[r_scan_idx[IW-1:0]];
    end

    // next event being built
    always_comb begin
        n_res = r_res;
        if (i_cmd.do_load) begin
            n_res = '0;
            if (load_ok) begin
                n_res.kind    = KIND_LOADED;
                n_res.proc_id = PID_W'(r_count + CW'(1));
            end else begin
                n_res.kind = KIND_REFUSED;
            end
        end
        if (i_cmd.do_clear) begin
            n_res      = '0;
            n_res.kind = KIND_CLEARED;
        end
        if (i_cmd.set_idle) begin
            n_res            = '0;
            n_res.kind       = KIND_IDLE;
            n_res.start_time = r_clock;
            n_res.run_length = VAL_W'(1);
        end
        if (i_cmd.set_done) begin
            n_res            = '0;
            n_res.kind       = KIND_DONE;
            n_res.start_time = r_clock;
        end
        if (i_cmd.run_start) begin
            n_res            = '0;
            n_res.kind       = r_scan_sys ? KIND_SYS_RUN : KIND_USER_SLICE;
            n_res.proc_id    = PID_W'(r_best_idx) + PID_W'(1);
            n_res.start_time = r_clock;
            n_res.run_length = run_len;
            if (rem_new == '0) begin
                n_res.completed       = 1'b1;
                n_res.completion_time = clock_next;
            end
        end
        if (i_cmd.run_tat && r_res.completed) begin
            n_res.turnaround = r_res.completion_time -
                               {{(TIME_W-VAL_W){1'b0}}, r_best_arr};
        end
        if (i_cmd.run_wait && r_res.completed) begin
            n_res.waiting = r_res.turnaround -
                            {{(TIME_W-VAL_W){1'b0}}, r_best_burst};
        end
    end

    // request capture and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op       <= i_op;
            r_arr_in   <= i_arrival;
            r_burst_in <= i_burst;
            r_cls_in   <= i_proc_class;
        end
        if (i_cmd.scan_step && take) begin
            r_best_idx   <= r_pipe_idx;
            r_best_arr   <= r_rd.arrival;
            r_best_burst <= r_rd.burst;
            r_best_rem   <= r_rd.remaining;
        end
        if (i_cmd.scan_step) begin
            r_pipe_idx <= r_scan_idx[IW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
        r_res <= n_res;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_finished     <= '0;
            r_clock        <= '0;
            r_sweep_active <= 1'b0;
            r_sweep_pos    <= '0;
            r_ran_any      <= 1'b0;
            r_scan_idx     <= '0;
            r_scan_sys     <= 1'b0;
            r_pipe_vld     <= 1'b0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.do_load && load_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.do_clear) begin
                r_count        <= '0;
                r_finished     <= '0;
                r_clock        <= '0;
                r_sweep_active <= 1'b0;
                r_sweep_pos    <= '0;
                r_ran_any      <= 1'b0;
            end
            if (i_cmd.sweep_end) begin
                r_sweep_active <= 1'b0;
                r_sweep_pos    <= '0;
            end
            if (i_cmd.sweep_begin) begin
                r_sweep_active <= 1'b1;
                r_sweep_pos    <= '0;
                r_ran_any      <= 1'b0;
            end
            if (i_cmd.set_idle) begin
                r_clock <= r_clock + TIME_W'(1);
            end
            if (i_cmd.scan_start) begin
                r_scan_idx <= i_cmd.scan_from_pos ? r_sweep_pos : '0;
                r_scan_sys <= i_cmd.scan_sys;
                r_pipe_vld <= 1'b0;
                r_found    <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (issue) begin
                    r_scan_idx <= r_scan_idx + CW'(1);
                end
                r_pipe_vld <= issue;
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.run_start) begin
                r_clock <= clock_next;
                if (rem_new == '0) begin
                    r_finished <= r_finished + CW'(1);
                end
                if (!r_scan_sys) begin
                    r_sweep_pos <= CW'(r_best_idx) + CW'(1);
                    r_ran_any   <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.op           = r_op;
        o_sts.sweep_active = r_sweep_active;
        o_sts.all_done     = (r_finished >= r_count);
        o_sts.ran_any      = r_ran_any;
        o_sts.found        = r_found;
        o_sts.scan_done    = !issue && !r_pipe_vld;
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
endmodule
`default_nettype wire

// File: design/mqd_checker.sv
// port-level checks for the dispatcher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mqd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [mqd_pkg::KIND_W-1:0]   i_kind,
    input wire logic [mqd_pkg::PID_W-1:0]    i_proc_id,
    input wire logic [mqd_pkg::VAL_W-1:0]    i_run_length,
    input wire logic                         i_completed,
    input wire logic [mqd_pkg::TIME_W-1:0]   i_completion_time,
    input wire logic [mqd_pkg::TIME_W-1:0]   i_turnaround,
    input wire logic [mqd_pkg::TIME_W-1:0]   i_waiting
);
    import mqd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind))
        else $error("event dropped while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event present after reset");

    a_cmpl_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_completed |-> (i_kind == KIND_SYS_RUN || i_kind == KIND_USER_SLICE))
        else $error("completion on a non-run event");

    a_no_times: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_completed |->
            i_completion_time == '0 && i_turnaround == '0 && i_waiting == '0)
        else $error("times reported without completion");

    a_idle_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_IDLE |-> i_run_length == 16'd1 && i_proc_id == '0)
        else $error("malformed idle tick");
endmodule

bind multilevel_queue_dispatcher_top mqd_checker u_mqd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_kind            (o_out.kind),
    .i_proc_id         (o_out.proc_id),
    .i_run_length      (o_out.run_length),
    .i_completed       (o_out.completed),
    .i_completion_time (o_out.completion_time),
    .i_turnaround      (o_out.turnaround),
    .i_waiting         (o_out.waiting)
);
`default_nettype wire
